### hdl/hps_pkg.sv
// shared constants, types and helpers of the hash partition slot assigner
package hps_pkg;

  localparam int unsigned MAX_PARTITIONS = 256;
  localparam int unsigned COUNT_WIDTH    = 32;

  // fixed field widths
  localparam int unsigned HASH_W     = 64;
  localparam int unsigned CFG_W      = 9;
  localparam int unsigned PART_IDX_W = 8;
  localparam int unsigned SLOT_W     = 32;

  // derived widths
  localparam int unsigned PART_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int unsigned DIV_W  = $clog2(MAX_PARTITIONS + 1);
  localparam int unsigned SH_W   = PART_W + 1;
  localparam int unsigned EFF_W  = (DIV_W > CFG_W) ? DIV_W : CFG_W;

  // remainder unit: hash bits consumed per cycle
  localparam int unsigned BITS_PER_STEP = 8;
  localparam int unsigned DIV_STEPS     = HASH_W / BITS_PER_STEP;
  localparam int unsigned STEP_W        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [PART_W-1:0]      part_t;
  typedef logic [DIV_W-1:0]       divisor_t;

  localparam count_t CNT_MAX = '1;

  // zero acts as one, anything above the table size acts as the table size
  function automatic divisor_t eff_divisor(input logic [CFG_W-1:0] cfg);
    logic [EFF_W-1:0] n;
    n = EFF_W'(cfg);
    if (n == '0) begin
      n = EFF_W'(1);
    end
    if (n > EFF_W'(MAX_PARTITIONS)) begin
      n = EFF_W'(MAX_PARTITIONS);
    end
    return DIV_W'(n);
  endfunction

endpackage

### hdl/hps_if.sv
// valid/ready channel interfaces for hash input and slot result
interface hps_in_if;
  logic                         valid;
  logic                         ready;
  logic [hps_pkg::HASH_W-1:0]   tuple_hash;
  logic                         batch_end;

  modport source (output valid, output tuple_hash, output batch_end, input ready);
  modport sink   (input valid, input tuple_hash, input batch_end, output ready);
endinterface

interface hps_out_if;
  logic                           valid;
  logic                           ready;
  logic [hps_pkg::PART_IDX_W-1:0] part_index;
  logic [hps_pkg::SLOT_W-1:0]     slot_offset;
  logic                           count_overflow;
  logic                           batch_end_out;

  modport source (output valid, output part_index, output slot_offset,
                  output count_overflow, output batch_end_out, input ready);
  modport sink   (input valid, input part_index, input slot_offset,
                  input count_overflow, input batch_end_out, output ready);
endinterface

### hdl/hps_ram.sv
// generic single-write, single-read ram with registered read data
module hps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/hps_mod_unit.sv
// iterative remainder unit: hash modulo partition count, several bits per cycle
module hps_mod_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hps_pkg::HASH_W-1:0]   dividend_i,
  input  hps_pkg::divisor_t            divisor_i,
  output logic                         done_o,
  output hps_pkg::part_t               rem_o
);

  logic [hps_pkg::HASH_W-1:0]  hash_q, hash_d;
  hps_pkg::part_t              rem_q, rem_d;
  logic [hps_pkg::STEP_W-1:0]  step_q, step_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;

  // restoring remainder over one group of hash bits, msb first
  always_comb begin
    logic [hps_pkg::SH_W-1:0] t;
    hash_d = hash_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    t      = '0;
    if (start_i) begin
      hash_d = dividend_i;
      rem_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      for (int unsigned b = 0; b < hps_pkg::BITS_PER_STEP; b++) begin
        t = {rem_d, hash_q[hps_pkg::HASH_W-1-b]};
        if (t >= hps_pkg::SH_W'(divisor_i)) begin
          t = t - hps_pkg::SH_W'(divisor_i);
        end
        rem_d = t[hps_pkg::PART_W-1:0];
      end
      hash_d = hash_q << hps_pkg::BITS_PER_STEP;
      step_d = step_q + 1'b1;
      if (step_q == hps_pkg::STEP_W'(hps_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### hdl/hash_partition_slot_assign_top.sv
// top level of the hash partition slot assigner
//
// usage:
//   in_i carries one 64-bit tuple hash plus a batch-end flag per transfer.
//   out_o returns, per hash, the partition (hash modulo the partition count),
//   the slot offset (fill count of that partition before this tuple), an
//   overflow flag for a saturated counter, and the batch-end flag copied over.
//   cfg_we_i/cfg_wdata_i write the partition count; write it only while idle.
//   a count of zero acts as one, a count above the table size acts as the
//   table size.
// timing:
//   one item at a time. an item passes from input transfer to result on
//   out_o through the remainder unit (8 hash bits per cycle), the ram read,
//   the update state and the output register.
//   a new hash is taken only after the previous one has been loaded into
//   the output register.
// reset and stall:
//   reset clears all fill counters at once through per-partition valid bits
//   and sets the partition count to one. a stalled out_o holds its result;
//   the next item still enters and is computed, then waits in the update
//   cycle until the output register frees up.
module hash_partition_slot_assign_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  hps_in_if.sink                      in_i,
  hps_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [hps_pkg::CFG_W-1:0]   cfg_wdata_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD
  } state_e;

  state_e                         state_q;
  hps_pkg::divisor_t              div_q;
  hps_pkg::part_t                 part_q;
  logic                           batch_q;
  logic [hps_pkg::MAX_PARTITIONS-1:0] valid_q;

  // output register
  logic                           out_valid_q;
  logic [hps_pkg::PART_IDX_W-1:0] out_part_q;
  logic [hps_pkg::SLOT_W-1:0]     out_slot_q;
  logic                           out_ovf_q;
  logic                           out_batch_q;

  // remainder unit
  logic                           div_start;
  logic                           div_done;
  hps_pkg::part_t                 div_rem;

  // counter ram
  logic                           ram_re;
  logic                           ram_we;
  hps_pkg::count_t                ram_rdata;
  hps_pkg::count_t                ram_wdata;

  hps_pkg::count_t                cur_cnt;
  logic                           cur_ovf;
  logic                           commit;
  logic                           in_xfer;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign div_start  = in_xfer;

  // issue the counter read as the remainder comes out
  assign ram_re = (state_q == ST_DIV) && div_done;

  // never-written counters read as zero
  assign cur_cnt   = valid_q[part_q] ? ram_rdata : '0;
  assign cur_ovf   = (cur_cnt == hps_pkg::CNT_MAX);
  assign commit    = (state_q == ST_UPD) && (!out_valid_q || out_o.ready);
  assign ram_we    = commit && !cur_ovf;
  assign ram_wdata = cur_cnt + 1'b1;

  hps_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_i.tuple_hash),
    .divisor_i  (div_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  hps_ram #(
    .WIDTH (hps_pkg::COUNT_WIDTH),
    .DEPTH (hps_pkg::MAX_PARTITIONS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (part_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (div_rem),
    .rdata_o (ram_rdata)
  );

  // partition count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= hps_pkg::DIV_W'(1);
    end else if (cfg_we_i) begin
      div_q <= hps_pkg::eff_divisor(cfg_wdata_i);
    end
  end

  // sequencer, valid bits and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      part_q      <= '0;
      batch_q     <= 1'b0;
      out_part_q  <= '0;
      out_slot_q  <= '0;
      out_ovf_q   <= 1'b0;
      out_batch_q <= 1'b0;
    end else begin
      // drained result with nothing new to load frees the output register
      if (out_valid_q && out_o.ready && !commit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            batch_q <= in_i.batch_end;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            part_q  <= div_rem;
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          // wait here while the previous result is still held
          if (commit) begin
            valid_q[part_q] <= 1'b1;
            out_valid_q     <= 1'b1;
            out_part_q      <= hps_pkg::PART_IDX_W'(part_q);
            out_slot_q      <= hps_pkg::SLOT_W'(cur_cnt);
            out_ovf_q       <= cur_ovf;
            out_batch_q     <= batch_q;
            state_q         <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.part_index     = out_part_q;
  assign out_o.slot_offset    = out_slot_q;
  assign out_o.count_overflow = out_ovf_q;
  assign out_o.batch_end_out  = out_batch_q;

  // remainder only comes back for an item in flight
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("remainder unit finished outside the divide phase");

  // chosen partition is below the partition count
  a_part_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |-> hps_pkg::SH_W'(part_q) < hps_pkg::SH_W'(div_q))
    else $error("partition index not below partition count");

  // counter never wraps through zero
  a_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ram_wdata != '0)
    else $error("fill counter wrapped");

  // a loaded result is presented on out_o with the sequencer back in idle
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q && state_q == ST_IDLE)
    else $error("result not presented after update");

endmodule
